/* sv/gced_pkg.sv */
package gced_pkg;

    // Field and register widths fixed by the interface.
    localparam int CHAN_W    = 8;
    localparam int LINE_W    = 10;
    localparam int COEF_W    = 24;
    localparam int REG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CURVE_CONST  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CURVE_LINEAR = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CURVE_SQUARE = 2'd3;

    // Register reset values.
    localparam int LINE_WIDTH_RESET   = 512;
    localparam int CURVE_CONST_RESET  = 0;
    localparam int CURVE_LINEAR_RESET = 65536;
    localparam int CURVE_SQUARE_RESET = 0;

    // Luma weights in Q8 and the resulting gray width (0..1024, Q10).
    localparam int GRAY_R    = 312;
    localparam int GRAY_G    = 591;
    localparam int GRAY_B    = 126;
    localparam int GSUM_W    = 19;
    localparam int GRAY_FRAC = 8;
    localparam int GRAY_W    = GSUM_W - GRAY_FRAC;

    // Curve evaluation: value * 2^36 = K*2^20 + L*gray*2^10 + S*gray^2.
    localparam int K_SHIFT = 20;
    localparam int L_SHIFT = 10;
    localparam int Y_SHIFT = 26;
    localparam int LIN_W   = COEF_W + GRAY_W + 1;
    localparam int SQ_W    = 2 * GRAY_W;
    localparam int SQK_W   = COEF_W + SQ_W + 1;
    localparam int TOT_W   = 48;
    localparam int Q_W     = TOT_W - Y_SHIFT;
    localparam int Y_MAX   = 1024;
    localparam int THRESH  = 512;

    // Error store entries and the error term taken from them.
    localparam int ERR_W     = 16;
    localparam int ERR_SHIFT = 4;
    localparam int ERR_ROUND = (1 << ERR_SHIFT) - 1;
    localparam int E_W       = ERR_W - ERR_SHIFT;
    localparam int S_W       = E_W + 1;

    // Floyd-Steinberg weights: right, below left, below, below right.
    localparam int W_RIGHT = 7;
    localparam int W_DL    = 3;
    localparam int W_DOWN  = 5;
    localparam int W_DR    = 1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              image_start;
    } gced_in_t;

    typedef struct packed {
        logic pixel_white;
        logic row_end;
    } gced_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQR,
        S_SUM,
        S_DEC,
        S_FLUSH
    } gced_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sqr;
        logic sum;
        logic decide;
        logic flush;
    } gced_cmd_t;

    typedef struct packed {
        logic last;
    } gced_status_t;

endpackage

/* sv/gced_ram.sv */
module gced_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/gced_dp.sv */
module gced_dp #(
    parameter int MAX_COLS = 512
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [gced_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [gced_pkg::COEF_W-1:0]          cfg_wr_data,
    input  gced_pkg::gced_in_t                   s_data,
    input  gced_pkg::gced_cmd_t                  cmd,
    output gced_pkg::gced_status_t               st,
    output gced_pkg::gced_out_t                  m_data
);

    import gced_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int FW = CW + 1;
    localparam int AW = $clog2(2 * MAX_COLS);
    localparam int LW = (FW > LINE_W) ? FW : LINE_W;

    // Configuration registers.
    logic [LINE_W-1:0]        line_width_reg;
    logic signed [COEF_W-1:0] curve_const_reg;
    logic signed [COEF_W-1:0] curve_linear_reg;
    logic signed [COEF_W-1:0] curve_square_reg;

    // Row state.
    logic [CW-1:0]    column_reg;
    logic             active_reg;
    logic [FW-1:0]    fill_reg;
    logic [ERR_W-1:0] p0_reg;
    logic [ERR_W-1:0] p1_reg;
    logic [ERR_W-1:0] carry_reg;

    // Per-pixel pipeline registers.
    logic [GRAY_W-1:0]       gray_reg;
    logic                    rd_valid_reg;
    logic signed [E_W-1:0]   e_reg;
    logic signed [LIN_W-1:0] lin_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic signed [SQK_W-1:0] sqk_reg;
    logic [TOT_W-1:0]        part_reg;
    logic [GRAY_W-1:0]       y_reg;
    gced_out_t               out_reg;

    logic [LW-1:0]           lw_ext;
    logic [FW-1:0]           w_eff;
    logic [GSUM_W-1:0]       gray_sum;
    logic [GRAY_W-1:0]       gray_next;
    logic                    rd_row;
    logic [CW-1:0]           rd_col;
    logic [AW-1:0]           rd_addr;
    logic                    rd_valid_next;
    logic [ERR_W-1:0]        ram_rdata;
    logic [ERR_W-1:0]        err_mem;
    logic [ERR_W-1:0]        err_sum;
    logic [ERR_W-1:0]        err_adj;
    logic signed [LIN_W-1:0] lin_next;
    logic [SQ_W-1:0]         sq_next;
    logic signed [SQK_W-1:0] sqk_next;
    logic [TOT_W-1:0]        part_next;
    logic [TOT_W-1:0]        total;
    logic [Q_W-1:0]          q_val;
    logic [GRAY_W-1:0]       y_next;
    logic signed [S_W-1:0]   s_val;
    logic signed [S_W-1:0]   ediff_w;
    logic                    white;
    logic [ERR_W-1:0]        e1;
    logic [ERR_W-1:0]        e3;
    logic [ERR_W-1:0]        e5;
    logic [ERR_W-1:0]        e7;
    logic [FW-1:0]           x_ext;
    logic                    last;
    logic                    c3;
    logic                    c5;
    logic [ERR_W-1:0]        dl_value;
    logic [ERR_W-1:0]        p0_next;
    logic                    wr_en;
    logic [CW-1:0]           wr_col;
    logic [AW-1:0]           wr_addr;
    logic [ERR_W-1:0]        wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_W'(LINE_WIDTH_RESET);
            curve_const_reg  <= COEF_W'(CURVE_CONST_RESET);
            curve_linear_reg <= COEF_W'(CURVE_LINEAR_RESET);
            curve_square_reg <= COEF_W'(CURVE_SQUARE_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_wr_data[LINE_W-1:0];
                REG_CURVE_CONST:  curve_const_reg  <= cfg_wr_data;
                REG_CURVE_LINEAR: curve_linear_reg <= cfg_wr_data;
                REG_CURVE_SQUARE: curve_square_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Width in use: zero acts as one, anything above MAX_COLS is clipped.
    always_comb begin
        lw_ext = LW'(line_width_reg);
        if (line_width_reg == '0) begin
            w_eff = FW'(1);
        end else if (lw_ext > LW'(MAX_COLS)) begin
            w_eff = FW'(MAX_COLS);
        end else begin
            w_eff = FW'(lw_ext);
        end
    end

    // Accept stage: gray value and the read of this column's stored error.
    always_comb begin
        gray_sum = GSUM_W'(s_data.red) * GSUM_W'(GRAY_R)
                 + GSUM_W'(s_data.green) * GSUM_W'(GRAY_G)
                 + GSUM_W'(s_data.blue) * GSUM_W'(GRAY_B);
        gray_next = gray_sum[GSUM_W-1:GRAY_FRAC];
        rd_row = s_data.image_start ? 1'b0 : active_reg;
        rd_col = s_data.image_start ? '0 : column_reg;
        rd_addr = (rd_row ? AW'(MAX_COLS) : '0) + AW'(rd_col);
        // Entries at or past the fill mark of the current row store read as zero.
        rd_valid_next = !s_data.image_start && ({1'b0, column_reg} < fill_reg);
    end

    // Multiply stage: error term, linear product and gray squared.
    always_comb begin
        err_mem = rd_valid_reg ? ram_rdata : '0;
        err_sum = err_mem + carry_reg;
        err_adj = err_sum + (err_sum[ERR_W-1] ? ERR_W'(ERR_ROUND) : '0);
        lin_next = curve_linear_reg * $signed({1'b0, gray_reg});
        sq_next = gray_reg * gray_reg;
    end

    // Square stage and the constant plus linear partial sum.
    always_comb begin
        sqk_next = curve_square_reg * $signed({1'b0, sq_reg});
        part_next = ({{(TOT_W-COEF_W){curve_const_reg[COEF_W-1]}}, curve_const_reg} << K_SHIFT)
                  + ({{(TOT_W-LIN_W){lin_reg[LIN_W-1]}}, lin_reg} << L_SHIFT);
    end

    // Sum stage: total in Q36, truncated to Q10 and clamped.
    always_comb begin
        total = part_reg + {{(TOT_W-SQK_W){sqk_reg[SQK_W-1]}}, sqk_reg};
        q_val = total[TOT_W-1:Y_SHIFT];
        if (total[TOT_W-1]) begin
            y_next = '0;
        end else if (q_val > Q_W'(Y_MAX)) begin
            y_next = GRAY_W'(Y_MAX);
        end else begin
            y_next = q_val[GRAY_W-1:0];
        end
    end

    // Decide stage: threshold, residual and its spread.
    always_comb begin
        s_val = $signed({2'b00, y_reg}) + $signed({e_reg[E_W-1], e_reg});
        white = s_val > $signed(S_W'(THRESH));
        ediff_w = white ? (s_val - $signed(S_W'(Y_MAX))) : s_val;
        e1 = {{(ERR_W-E_W){ediff_w[E_W-1]}}, ediff_w[E_W-1:0]};
        e3 = ERR_W'(e1 * ERR_W'(W_DL));
        e5 = ERR_W'(e1 * ERR_W'(W_DOWN));
        e7 = ERR_W'(e1 * ERR_W'(W_RIGHT));
        x_ext = {1'b0, column_reg};
        last = (x_ext + FW'(1)) >= w_eff;
        // The below-left term drops at the left edge and once the column is
        // past the width; the term below drops at or past the width.
        c3 = (column_reg != '0) && (x_ext <= w_eff);
        c5 = x_ext < w_eff;
        dl_value = p0_reg + (c3 ? e3 : '0);
        p0_next = p1_reg + (c5 ? e5 : '0);
    end

    // The next row store is written once per entry, in column order.
    always_comb begin
        wr_en = (cmd.decide && (column_reg != '0)) || cmd.flush;
        wr_col = cmd.flush ? column_reg : CW'(column_reg - CW'(1));
        wr_addr = (active_reg ? '0 : AW'(MAX_COLS)) + AW'(wr_col);
        wr_data = cmd.flush ? p0_reg : dl_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            active_reg <= 1'b0;
            fill_reg   <= '0;
            p0_reg     <= '0;
            p1_reg     <= '0;
            carry_reg  <= '0;
        end else begin
            if (cmd.load && s_data.image_start) begin
                column_reg <= '0;
                active_reg <= 1'b0;
                fill_reg   <= '0;
                p0_reg     <= '0;
                p1_reg     <= '0;
                carry_reg  <= '0;
            end
            if (cmd.decide) begin
                p0_reg    <= p0_next;
                p1_reg    <= e1;
                carry_reg <= e7;
                if (!last) begin
                    column_reg <= column_reg + CW'(1);
                end
            end
            if (cmd.flush) begin
                active_reg <= ~active_reg;
                column_reg <= '0;
                fill_reg   <= x_ext + FW'(1);
                p0_reg     <= '0;
                p1_reg     <= '0;
                carry_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gray_reg     <= gray_next;
            rd_valid_reg <= rd_valid_next;
        end
        if (cmd.mul) begin
            e_reg   <= $signed(err_adj[ERR_W-1:ERR_SHIFT]);
            lin_reg <= lin_next;
            sq_reg  <= sq_next;
        end
        if (cmd.sqr) begin
            sqk_reg  <= sqk_next;
            part_reg <= part_next;
        end
        if (cmd.sum) begin
            y_reg <= y_next;
        end
        if (cmd.decide) begin
            out_reg.pixel_white <= white;
            out_reg.row_end     <= last;
        end
    end

    gced_ram #(
        .WIDTH (ERR_W),
        .DEPTH (2 * MAX_COLS)
    ) u_err_rows (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.load),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    assign st.last = last;
    assign m_data  = out_reg;

endmodule

/* sv/gced_ctrl.sv */
module gced_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  gced_pkg::gced_status_t st,
    output gced_pkg::gced_cmd_t    cmd
);

    import gced_pkg::*;

    gced_state_t state_reg;
    gced_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_SQR;
            end
            S_SQR: begin
                cmd.sqr    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_DEC;
            end
            S_DEC: begin
                if (out_free) begin
                    cmd.decide = 1'b1;
                    state_next = st.last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_valid_next = cmd.decide ? 1'b1 : (m_valid_reg && !m_ready);
    end

    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_flush_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> ($past(cmd.decide) && $past(st.last)))
        else $error("row flush without a last pixel decided just before");

    a_fixed_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> ##3 cmd.sum)
        else $error("curve chain did not reach the sum step in three cycles");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.mul, cmd.sqr, cmd.sum, cmd.decide, cmd.flush}))
        else $error("more than one datapath command in a cycle");
`endif

endmodule

/* sv/gray_curve_error_diffusion_dither.sv */
// Gray-curve error-diffusion dither, one bit per pixel out.
// Pixels arrive in raster order on the s_ channel (valid/ready); a request is
// taken when s_valid and s_ready are both high. Set image_start on the first
// pixel of an image to clear the error rows. Each pixel yields one request on
// the m_ channel carrying the dithered bit and a row_end flag.
// Configuration (line width and the three Q16 curve coefficients) is written
// through cfg_wr_en / cfg_index / cfg_wr_data, one register per cycle; the user
// must write it only while no pixel is in flight, as the block does not enforce it.
// A taken request steps through the multiply, square, sum and decide states;
// m_valid is registered at the decide step. The next pixel is taken only after
// the decide step, as set by the multiply chain (gray squared, then the square
// coefficient, then the wide sum) and by the single write port of the error
// row memory, which writes the final entry of a row in an extra flush state.
// Reset (aresetn low, synchronous) empties both channels, restores the
// register defaults and marks both error rows as zero; no clearing pass runs.
// If the receiver stalls, the finished result waits in the output register
// while the next pixel is accepted and computed; that pixel then holds
// before its decision step until the output register is free.
module gray_curve_error_diffusion_dither #(
    parameter int MAX_COLS = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [gced_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [gced_pkg::COEF_W-1:0]    cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  gced_pkg::gced_in_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output gced_pkg::gced_out_t            m_data
);

    import gced_pkg::*;

    // Controller commands step the datapath one stage per cycle; decide may wait.
    gced_cmd_t    cmd;
    gced_status_t st;

    gced_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // The datapath holds the registers, the curve arithmetic and the two
    // ping-pong error rows; the current row is read once per pixel and the
    // next row is written in column order.
    gced_dp #(
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .st          (st),
        .m_data      (m_data)
    );

endmodule

/* test/gray_curve_error_diffusion_dither_test.sv */
`timescale 1ns / 1ps

module gray_curve_error_diffusion_dither_test;

    import gced_pkg::*;

    // The row store depth matches the block's default parameter.
    localparam int ROW_CAP   = 512;
    localparam int HALF_CLK  = 10;
    localparam int GAP_MAX   = 17;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = 20;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    gced_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    gced_out_t            m_data;

    gray_curve_error_diffusion_dither #(
        .MAX_COLS(ROW_CAP)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always #HALF_CLK aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow copy of the dither state and registers. The error rows are
    // kept as two halves of one array, just as the block keeps them, and
    // every entry wraps at 16 bits.
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] err_line [2*ROW_CAP];
    logic                    row_sel;
    int unsigned             col_pos;
    logic [LINE_W-1:0]       width_reg;
    int                      curve_k;
    int                      curve_l;
    int                      curve_s;

    // Expected dithered bits, oldest first.
    gced_out_t dither_queue[$];

    // Run bookkeeping.
    int  fail_count;
    int  checked_count;
    int  row_end_count;
    int  white_count;
    int  setting_count;
    bit  gaps_off;
    int  hold_off;
    bit  held_long;

    // Adds a diffused share to one error entry, wrapping like the store.
    function automatic void spread_error(int unsigned idx, int amount);
        err_line[idx] = ERR_W'(int'(err_line[idx]) + amount);
    endfunction

    // Computes the dithered bit for one accepted pixel and moves the shadow
    // state forward by one pixel.
    function automatic gced_out_t dither_predict(gced_in_t px);
        int unsigned w;
        int unsigned xpos;
        int unsigned cur;
        int unsigned nxt;
        longint      gray;
        longint      total;
        longint      y;
        int          e;
        int          s;
        int          ediff;
        gced_out_t   res;

        w = width_reg;
        if (w < 1) w = 1;
        if (w > ROW_CAP) w = ROW_CAP;

        // The first pixel of an image starts from clean error rows.
        if (px.image_start) begin
            for (int i = 0; i < 2 * ROW_CAP; i++) err_line[i] = '0;
            row_sel = 1'b0;
            col_pos = 0;
        end

        xpos = col_pos;
        if (xpos >= ROW_CAP) xpos = ROW_CAP - 1;
        cur = row_sel ? ROW_CAP : 0;
        nxt = row_sel ? 0 : ROW_CAP;

        gray = (int'(px.red) * GRAY_R + int'(px.green) * GRAY_G
                + int'(px.blue) * GRAY_B) / 256;

        // Curve value scaled by 2^36, then brought down to Q10 with
        // truncation toward zero and clamped to the legal gray range.
        total = longint'(curve_k) * (longint'(1) << K_SHIFT)
              + longint'(curve_l) * gray * (longint'(1) << L_SHIFT)
              + longint'(curve_s) * gray * gray;
        y = total / (longint'(1) << Y_SHIFT);
        if (y < 0) y = 0;
        if (y > Y_MAX) y = Y_MAX;

        e = int'(err_line[cur + xpos]) / 16;
        s = int'(y) + e;
        if (s > THRESH) begin
            res.pixel_white = 1'b1;
            ediff = s - 1024;
        end else begin
            res.pixel_white = 1'b0;
            ediff = s;
        end

        // Shares that would land outside the row are dropped.
        if (xpos + 1 < w) spread_error(cur + xpos + 1, W_RIGHT * ediff);
        if (xpos >= 1 && xpos - 1 < w) spread_error(nxt + xpos - 1, W_DL * ediff);
        if (xpos < w) spread_error(nxt + xpos, W_DOWN * ediff);
        if (xpos + 1 < w) spread_error(nxt + xpos + 1, W_DR * ediff);

        // At the end of a row the current store is wiped and reused as the
        // row below the next one.
        res.row_end = (col_pos + 1 >= w);
        if (res.row_end) begin
            for (int i = 0; i < ROW_CAP; i++) err_line[cur + i] = '0;
            row_sel = ~row_sel;
            col_pos = 0;
        end else begin
            col_pos = col_pos + 1;
        end
        return res;
    endfunction

    // Mirrors one register write into the shadow registers.
    function automatic void shadow_register(logic [REG_IDX_W-1:0] idx,
                                            logic [COEF_W-1:0] val);
        case (idx)
            REG_LINE_WIDTH:   width_reg = val[LINE_W-1:0];
            REG_CURVE_CONST:  curve_k = int'($signed(val));
            REG_CURVE_LINEAR: curve_l = int'($signed(val));
            REG_CURVE_SQUARE: curve_s = int'($signed(val));
            default: ;
        endcase
    endfunction

    // Number of idle cycles before the next request on either side.
    function automatic int draw_gap();
        if (gaps_off) return 0;
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Each call starts and ends on a rising edge. The valid
    // line is only lowered when a gap follows, so back-to-back pixels keep
    // s_valid high without a second assignment in the same step.
    // ------------------------------------------------------------------
    task automatic send_pixel(input gced_in_t px);
        int gap;

        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        dither_queue.push_back(dither_predict(px));
    endtask

    // Stops offering pixels and waits until every expected bit has come
    // back, which leaves the block idle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (dither_queue.size() != 0) @(posedge aclk);
    endtask

    // Writes all four registers, one per cycle, while the block is idle.
    task automatic configure(input logic [LINE_W-1:0] width, input logic [COEF_W-1:0] k,
                             input logic [COEF_W-1:0] l, input logic [COEF_W-1:0] sq);
        logic [REG_IDX_W-1:0] idx_list [4];
        logic [COEF_W-1:0]    val_list [4];

        idx_list = '{REG_LINE_WIDTH, REG_CURVE_CONST, REG_CURVE_LINEAR, REG_CURVE_SQUARE};
        val_list = '{COEF_W'(width), k, l, sq};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx_list[i];
            cfg_wr_data <= val_list[i];
            @(posedge aclk);
            shadow_register(idx_list[i], val_list[i]);
        end
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    function automatic gced_in_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic start);
        gced_in_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        px.image_start = start;
        return px;
    endfunction

    // Random pixel: full range half the time, neutral grays or
    // saturated channels otherwise.
    function automatic gced_in_t random_pixel(logic start);
        logic [7:0] v;
        case ($urandom_range(0, 3))
            0: begin
                v = 8'($urandom);
                return make_pixel(v, v, v, start);
            end
            1: return make_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00,
                                 $urandom_range(0, 1) ? 8'hFF : 8'h00,
                                 $urandom_range(0, 1) ? 8'hFF : 8'h00, start);
            default: return make_pixel(8'($urandom), 8'($urandom), 8'($urandom), start);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side. Each result waits a random number of cycles; when a
    // long hold is requested it drops ready for that many counted cycles
    // while the sender keeps offering pixels.
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall;

        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (hold_off > 0) begin
                stall = hold_off;
                hold_off = 0;
                held_long = 1'b1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_valid || hold_off > 0) break;
            end
        end
    end

    // Compares every accepted result request with the oldest expectation.
    always @(posedge aclk) begin : result_check
        gced_out_t want;

        if (aresetn && m_valid && m_ready) begin
            if (dither_queue.size() == 0) begin
                $display("%0t ns: result with no pixel pending, actual white=%0b row_end=%0b",
                         $time, m_data.pixel_white, m_data.row_end);
                fail_count++;
            end else begin
                want = dither_queue.pop_front();
                checked_count++;
                if (want.row_end) row_end_count++;
                if (want.pixel_white) white_count++;
                if (m_data.pixel_white !== want.pixel_white) begin
                    $display("%0t ns: pixel_white mismatch, expected %0b, actual %0b",
                             $time, want.pixel_white, m_data.pixel_white);
                    fail_count++;
                end
                if (m_data.row_end !== want.row_end) begin
                    $display("%0t ns: row_end mismatch, expected %0b, actual %0b",
                             $time, want.row_end, m_data.row_end);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // Reset defaults: identity curve on a full-width row with the darkest,
    // brightest and single-channel pixels.
    task automatic test_default_extremes();
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
        send_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'h80, 8'h7F, 8'h80, 1'b0));
        drain_results();
    endtask

    // A width of zero behaves as one, so every pixel ends its row.
    task automatic test_width_limits();
        configure(LINE_W'(0), COEF_W'(CURVE_CONST_RESET), COEF_W'(CURVE_LINEAR_RESET),
                  COEF_W'(CURVE_SQUARE_RESET));
        send_pixel(make_pixel(8'h90, 8'h90, 8'h90, 1'b1));
        send_pixel(make_pixel(8'h70, 8'h70, 8'h70, 1'b0));
        drain_results();
        configure(LINE_W'(1), COEF_W'(CURVE_CONST_RESET), COEF_W'(CURVE_LINEAR_RESET),
                  COEF_W'(CURVE_SQUARE_RESET));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'h01, 8'hFE, 8'h01, 1'b0));
        drain_results();
    endtask

    // A width above the store size is clamped; lowering it while the row is
    // at column five ends that row right away, and none of that pixel's error
    // lands at or past the new width.
    task automatic test_width_lowered_mid_row();
        configure('1, COEF_W'(CURVE_CONST_RESET), COEF_W'(CURVE_LINEAR_RESET),
                  COEF_W'(CURVE_SQUARE_RESET));
        send_pixel(make_pixel(8'hC0, 8'h40, 8'h20, 1'b1));
        for (int i = 0; i < 4; i++) send_pixel(random_pixel(1'b0));
        drain_results();
        configure(LINE_W'(4), COEF_W'(CURVE_CONST_RESET), COEF_W'(CURVE_LINEAR_RESET),
                  COEF_W'(CURVE_SQUARE_RESET));
        send_pixel(make_pixel(8'h60, 8'h60, 8'h60, 1'b0));
        send_pixel(make_pixel(8'hA0, 8'hA0, 8'hA0, 1'b0));
        drain_results();
    endtask

    // Coefficient extremes push the curve hard against both clamps.
    task automatic test_curve_extremes();
        configure(LINE_W'(3), 24'h7FFFFF, COEF_W'(CURVE_LINEAR_RESET), '0);
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
        drain_results();
        configure(LINE_W'(3), 24'h800000, COEF_W'(CURVE_LINEAR_RESET), '0);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'h40, 8'h40, 8'h40, 1'b0));
        drain_results();
        configure(LINE_W'(3), '0, '0, 24'h7FFFFF);
        send_pixel(make_pixel(8'h10, 8'h10, 8'h10, 1'b0));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
        drain_results();
        configure(LINE_W'(3), '0, 24'h7FFFFF, 24'h800000);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'h20, 8'h20, 8'h20, 1'b0));
        drain_results();
    endtask

    // The receiver holds off for a long stretch while pixels keep coming,
    // so the output register and the next pixel fill up and s_ready drops.
    task automatic test_output_backpressure();
        configure(LINE_W'(6), COEF_W'(CURVE_CONST_RESET), COEF_W'(CURVE_LINEAR_RESET),
                  COEF_W'(CURVE_SQUARE_RESET));
        hold_off = LONG_HOLD;
        gaps_off = 1'b1;
        send_pixel(random_pixel(1'b1));
        for (int i = 0; i < 24; i++) send_pixel(random_pixel(1'b0));
        gaps_off = 1'b0;
        drain_results();
    endtask

    // Random images over several register settings. Most phases use short
    // rows so that many row ends and the row store rotation are exercised;
    // a few use the widest rows. Some phases run without idle cycles, and
    // every other phase pauses halfway until the block has emptied.
    task automatic test_random_images();
        logic [LINE_W-1:0] width;
        logic [COEF_W-1:0] k;
        logic [COEF_W-1:0] l;
        logic [COEF_W-1:0] sq;
        int                count;

        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 7))
                0:       width = LINE_W'($urandom_range(25, 200));
                1:       width = $urandom_range(0, 1) ? '1 : LINE_W'(0);
                default: width = LINE_W'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    k  = COEF_W'(CURVE_CONST_RESET);
                    l  = COEF_W'(CURVE_LINEAR_RESET);
                    sq = COEF_W'(CURVE_SQUARE_RESET);
                end
                1: begin
                    k  = COEF_W'($urandom);
                    l  = COEF_W'($urandom);
                    sq = COEF_W'($urandom);
                end
                default: begin
                    k  = COEF_W'(int'($urandom_range(0, 32768)) - 16384);
                    l  = COEF_W'($urandom_range(32768, 98304));
                    sq = COEF_W'(int'($urandom_range(0, 65536)) - 32768);
                end
            endcase
            configure(width, k, l, sq);
            gaps_off = (phase == 2 || phase == 5);
            count = $urandom_range(55, 75);
            for (int i = 0; i < count; i++) begin
                // An image normally starts each phase; a stray start now and
                // then restarts the image in the middle of a row.
                send_pixel(random_pixel(i == 0 ? ($urandom_range(0, 3) != 0)
                                               : ($urandom_range(0, 40) == 0)));
                if (phase % 2 == 1 && i == count / 2) drain_results();
            end
            gaps_off = 1'b0;
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : main_sequence
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_LINE_WIDTH;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        fail_count    = 0;
        checked_count = 0;
        row_end_count = 0;
        white_count   = 0;
        setting_count = 1;
        gaps_off  = 1'b0;
        hold_off  = 0;
        held_long = 1'b0;

        // Shadow state after reset.
        for (int i = 0; i < 2 * ROW_CAP; i++) err_line[i] = '0;
        row_sel   = 1'b0;
        col_pos   = 0;
        width_reg = LINE_W'(LINE_WIDTH_RESET);
        curve_k   = CURVE_CONST_RESET;
        curve_l   = CURVE_LINEAR_RESET;
        curve_s   = CURVE_SQUARE_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_extremes();
        test_width_limits();
        test_width_lowered_mid_row();
        test_curve_extremes();
        test_output_backpressure();
        test_random_images();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d dithered pixels (%0d white, %0d row ends) over %0d settings,",
                 checked_count, white_count, row_end_count, setting_count);
        $display("including clamped widths, a mid-row width cut and a long output hold (%0s).",
                 held_long ? "seen" : "missed");
        if (fail_count == 0) begin
            $display("** gray_curve_error_diffusion_dither: PASSED **");
        end else begin
            $display("** gray_curve_error_diffusion_dither: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin : watchdog
        #5_000_000;
        $display("** gray_curve_error_diffusion_dither: FAILED **");
        $finish;
    end

endmodule
